/* sv/spfl_pkg.sv */
// Shared types and codes for the slot pool free-list allocator.
`timescale 1ns / 1ps

package spfl_pkg;

   localparam int TARGET_W = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK           = 2'd0,
      STAT_FULL         = 2'd1,
      STAT_ALREADY_FREE = 2'd2,
      STAT_INVALID      = 2'd3
   } stat_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request, start slot table read
      logic execute;   // commit the request and load the result register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_busy;  // result register full and not being drained
   } dp_status_type;

endpackage

/* sv/spfl_ctrl.sv */
// Controller state machine for the slot pool free-list allocator.
`timescale 1ns / 1ps

module spfl_ctrl
   import spfl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // nothing is taken in while reset is held
            req_tready  = !reset;
            cmd.capture = req_tvalid && !reset;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold while the previous result is still waiting
            cmd.execute = !status.out_busy;
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_EXEC)
      else $error("capture did not move to execute");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && status.out_busy) |=> state_ff == ST_EXEC)
      else $error("left execute while result register was blocked");

   a_exec_done: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> state_ff == ST_IDLE)
      else $error("execute did not return to idle");

endmodule

/* sv/spfl_datapath.sv */
// Datapath: slot table, free-list pointers, live count and result register.
`timescale 1ns / 1ps

module spfl_datapath
   import spfl_pkg::*;
#(
   parameter int SLOTS = 256
)
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic                req_op,
   input  logic [TARGET_W-1:0] req_target,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [TARGET_W-1:0] rsp_slot,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_live
);

   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CMP_W = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;
   localparam int OUT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   // entry: top bit alive, low bits link to the next free slot
   logic [CNT_W:0] slot_table [SLOTS];

   logic [CNT_W:0]      rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   op_type              op_ff;
   logic [TARGET_W-1:0] target_ff;

   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] hw_ff, hw_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic                rsp_valid_ff;
   logic [TARGET_W-1:0] slot_ff;
   stat_type            stat_ff;
   logic [COUNT_W-1:0]  live_ff;

   logic [CMP_W-1:0] tgt_ext, hw_ext, head_ext, grant_ext;
   logic [OUT_W-1:0] live_ext;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [CNT_W:0]   wr_data;
   stat_type         stat_res;

   assign tgt_ext  = CMP_W'(target_ff);
   assign hw_ext   = CMP_W'(hw_ff);
   assign head_ext = CMP_W'(head_ff);

   // read address chosen from the incoming transaction
   always_comb begin
      logic [CMP_W-1:0] req_ext;
      req_ext = CMP_W'(req_target);
      if (op_type'(req_op) == OP_FREE) begin
         rd_addr = req_ext[IDX_W-1:0];
      end else begin
         rd_addr = head_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_data_ff <= slot_table[rd_addr];
         op_ff      <= op_type'(req_op);
         target_ff  <= req_target;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_table[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      head_in   = head_ff;
      hw_in     = hw_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = head_ff[IDX_W-1:0];
      wr_data   = {1'b1, CNT_W'(0)};
      stat_res  = STAT_OK;
      grant_ext = tgt_ext;
      unique case (op_ff)
         OP_FREE: begin
            if (tgt_ext == '0 || tgt_ext >= hw_ext || tgt_ext >= CMP_W'(SLOTS)) begin
               stat_res = STAT_INVALID;
            end else if (!rd_data_ff[CNT_W]) begin
               stat_res = STAT_ALREADY_FREE;
            end else begin
               // push onto the free list
               wr_en    = cmd.execute;
               wr_addr  = tgt_ext[IDX_W-1:0];
               wr_data  = {1'b0, head_ff};
               head_in  = tgt_ext[CNT_W-1:0];
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_ALLOC: begin
            grant_ext = head_ext;
            if (count_ff >= CNT_W'(SLOTS) || head_ff >= CNT_W'(SLOTS)) begin
               stat_res  = STAT_FULL;
               grant_ext = '0;
            end else begin
               if (head_ff == hw_ff) begin
                  // free list empty: take a fresh slot
                  hw_in   = hw_ff + CNT_W'(1);
                  head_in = head_ff + CNT_W'(1);
               end else begin
                  head_in = rd_data_ff[CNT_W-1:0];
               end
               wr_en    = cmd.execute;
               count_in = count_ff + CNT_W'(1);
            end
         end
         default: begin
            stat_res = STAT_INVALID;
         end
      endcase
   end

   assign live_ext = OUT_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= CNT_W'(1);
         hw_ff    <= CNT_W'(1);
         count_ff <= CNT_W'(1);
      end else if (cmd.execute) begin
         head_ff  <= head_in;
         hw_ff    <= hw_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.execute) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         slot_ff <= grant_ext[TARGET_W-1:0];
         stat_ff <= stat_res;
         live_ff <= live_ext[COUNT_W-1:0];
      end
   end

   assign status.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_status      = stat_ff;
   assign rsp_live        = live_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("live count above pool size");

   a_head_below_mark: assert property (@(posedge clock) disable iff (reset)
      head_ff <= hw_ff)
      else $error("free-list head beyond high-water mark");

   a_count_below_mark: assert property (@(posedge clock) disable iff (reset)
      count_ff <= hw_ff)
      else $error("live count exceeds slots ever handed out");

endmodule

/* sv/slot_pool_free_list_allocator.sv */
// Top level of the slot pool free-list allocator.
// Result: the result is loaded into the rsp_ register in the execute state that follows
//   acceptance of the request transaction; execute stalls while the previous result still waits.
// Transactions: a new request is not accepted until the previous one is committed;
//   the link or alive bit is read when the request is accepted and committed in execute.
// Reset: head, high-water mark and live count return to 1; req_tready is low in reset.
//   The slot table is not cleared; entries are trusted only below the high-water mark.
`timescale 1ns / 1ps

module slot_pool_free_list_allocator
   import spfl_pkg::*;
#(
   parameter int SLOTS = 256
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] target_slot
   input  logic        req_tuser,   // [0] op (0 allocate, 1 free)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] granted_slot, [9:8] status,
                                    // [18:10] live_count, [23:19] zero
);

   ctrl_cmd_type        cmd;
   dp_status_type       dp_status;
   logic [TARGET_W-1:0] rsp_slot;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_live;

   // controller: accepts one transaction, then commits it once the
   // result register has room
   spfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (cmd)
   );

   // datapath: slot table, pointers and the result register that lets a
   // new transaction in while the last result waits
   spfl_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (dp_status),
      .req_op     (req_tuser),
      .req_target (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_slot   (rsp_slot),
      .rsp_status (rsp_status),
      .rsp_live   (rsp_live)
   );

   assign rsp_tdata = {5'b0, rsp_live, rsp_status, rsp_slot};

endmodule
